>>> design/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types and constants for the base64 stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64d_pkg;

    localparam int CHAR_W   = 8;
    localparam int BCOUNT_W = 16;
    localparam int Q_DEPTH  = 4;
    localparam int Q_AW     = 2;
    localparam int Q_CW     = 3;

    localparam logic [CHAR_W-1:0] CH_PAD = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;

    localparam logic [BCOUNT_W-1:0] BCOUNT_MAX = 16'hFFFF;

    // one queued job: a decoded quartet or an end-of-message status
    typedef struct packed {
        logic                    is_status;
        logic                    status;
        logic [1:0]              nbytes;
        logic [2:0][CHAR_W-1:0]  bytes;
        logic [BCOUNT_W-1:0]     count;
    } t_job;

    // bit 6 flags a character outside the alphabet
    function automatic logic [6:0] f_digit(input logic [CHAR_W-1:0] ch);
        logic [6:0] d;
        d = 7'h40;
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            d = 7'(ch - 8'h41);
        end else if (ch >= 8'h61 && ch <= 8'h7A) begin
            d = 7'(ch - 8'h61 + 8'd26);
        end else if (ch >= 8'h30 && ch <= 8'h39) begin
            d = 7'(ch - 8'h30 + 8'd52);
        end else if (ch == 8'h2B) begin
            d = 7'd62;
        end else if (ch == 8'h2F) begin
            d = 7'd63;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

>>> design/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, groups quartets, decodes them and queues jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_front import b64d_pkg::*; #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CHAR_W-1:0] i_cfg_wdata,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [CHAR_W-1:0] i_char_in,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output t_job                   o_job
);

    logic [CHAR_W-1:0]     r_end_char;
    logic [CHAR_W-1:0]     r_held [3];
    logic [1:0]            r_phase;
    logic                  r_err;
    logic [COUNT_BITS-1:0] r_count;

    logic [1:0]            n_phase;
    logic                  n_err;
    logic [COUNT_BITS-1:0] n_count;

    logic                  acc;
    logic                  is_end;
    logic                  c2_pad, c3_pad;
    logic [6:0]            g0, g1, g2, g3;
    logic [5:0]            d2, d3;
    logic                  bad;
    logic [1:0]            nbytes;
    logic [COUNT_BITS:0]   sum;
    logic [COUNT_BITS+BCOUNT_W-1:0] cnt_ext;

    assign o_ready = !i_q_full;
    assign acc     = i_valid && o_ready;
    assign is_end  = (i_char_in == r_end_char);

    assign c2_pad = (r_held[2] == CH_PAD);
    assign c3_pad = (i_char_in == CH_PAD);
    assign g0     = f_digit(r_held[0]);
    assign g1     = f_digit(r_held[1]);
    assign g2     = f_digit(r_held[2]);
    assign g3     = f_digit(i_char_in);

    assign sum     = {1'b0, r_count} + (COUNT_BITS+1)'(nbytes);
    assign cnt_ext = (COUNT_BITS+BCOUNT_W)'(r_count);

    always_comb begin
        d2     = 6'd0;
        d3     = 6'd0;
        bad    = g0[6] | g1[6];
        nbytes = 2'd3;
        if (c3_pad && c2_pad) begin
            nbytes = 2'd1;
        end else if (c3_pad) begin
            d2     = g2[5:0];
            bad    = bad | g2[6];
            nbytes = 2'd2;
        end else begin
            d2  = g2[5:0];
            d3  = g3[5:0];
            bad = bad | g2[6] | g3[6];
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_err   = r_err;
        n_count = r_count;
        o_push  = 1'b0;
        o_job   = '0;
        if (acc) begin
            if (is_end) begin
                o_push          = 1'b1;
                o_job.is_status = 1'b1;
                o_job.status    = r_err || (r_phase != 2'd0);
                o_job.nbytes    = 2'd1;
                o_job.count     = (|cnt_ext[COUNT_BITS+BCOUNT_W-1:BCOUNT_W]) ?
                                  BCOUNT_MAX : cnt_ext[BCOUNT_W-1:0];
                n_phase         = 2'd0;
                n_err           = 1'b0;
                n_count         = '0;
            end else if (!r_err && i_char_in != CH_CR && i_char_in != CH_LF) begin
                if (r_phase != 2'd3) begin
                    n_phase = r_phase + 2'd1;
                end else begin
                    n_phase = 2'd0;
                    if (bad) begin
                        n_err = 1'b1;
                    end else begin
                        o_push       = 1'b1;
                        o_job.nbytes = nbytes;
                        o_job.bytes[0] = {g0[5:0], g1[5:4]};
                        o_job.bytes[1] = {g1[3:0], d2[5:2]};
                        o_job.bytes[2] = {d2[1:0], d3};
                        n_count = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_char <= '0;
            r_phase    <= 2'd0;
            r_err      <= 1'b0;
            r_count    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_end_char <= i_cfg_wdata;
            end
            r_phase <= n_phase;
            r_err   <= n_err;
            r_count <= n_count;
        end
    end

    // hold the first three characters of a quartet
    always_ff @(posedge i_clk) begin
        if (acc && !is_end && !r_err && i_char_in != CH_CR && i_char_in != CH_LF
            && r_phase != 2'd3) begin
            r_held[r_phase] <= i_char_in;
        end
    end

endmodule

`default_nettype wire

>>> design/b64d_fifo.sv
// ----------------------------------------------------------------------------
// b64d_fifo
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_fifo import b64d_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_job      o_head
);

    t_job            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_CW-1:0] r_cnt;

    assign o_full  = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("push into full job queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("pop from empty job queue");

    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("job queue fill count lost a push");

endmodule

`default_nettype wire

>>> design/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Expands queued jobs into result words through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_back import b64d_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_q_empty,
    input  t_job              i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [CHAR_W-1:0] o_data_byte,
    output logic              o_is_status,
    output logic              o_status,
    output logic [BCOUNT_W-1:0] o_byte_count,
    output logic              o_last
);

    logic                r_valid;
    logic [CHAR_W-1:0]   r_data_byte;
    logic                r_is_status;
    logic                r_status;
    logic [BCOUNT_W-1:0] r_byte_count;
    logic                r_last;
    logic [1:0]          r_idx;

    logic                load;
    logic                at_last;

    assign load    = (!r_valid || i_ready) && !i_q_empty;
    assign at_last = (r_idx == i_head.nbytes - 2'd1);
    assign o_pop   = load && at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_last ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_is_status  <= i_head.is_status;
            r_status     <= i_head.is_status & i_head.status;
            r_byte_count <= i_head.is_status ? i_head.count : '0;
            r_data_byte  <= i_head.is_status ? '0 : i_head.bytes[r_idx];
            r_last       <= at_last;
        end
    end

    assign o_valid      = r_valid;
    assign o_data_byte  = r_data_byte;
    assign o_is_status  = r_is_status;
    assign o_status     = r_status;
    assign o_byte_count = r_byte_count;
    assign o_last       = r_last;

    a_idx_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != 2'd0) |-> (!i_q_empty && !i_head.is_status))
        else $error("byte index advanced outside a data job");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_empty |-> (r_idx < i_head.nbytes))
        else $error("byte index past end of job");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_is_status) |-> r_last)
        else $error("status word not marked last");

endmodule

`default_nettype wire

>>> design/base64_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder_core
// Base64 text decoder: one character word in, byte or status words out.
// Each character's result words pass through a four-entry job queue and an
// output register. Throughput: one character per cycle in unless the queue is
// full, one word per cycle out on i_ready; a quartet yields up to three words.
// Reset: synchronous active-low; clears end char, quartet phase, error, count.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_decoder_core import b64d_pkg::*; #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [CHAR_W-1:0]   i_cfg_wdata,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [CHAR_W-1:0]   i_char_in,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [CHAR_W-1:0]        o_data_byte,
    output logic                     o_is_status,
    output logic                     o_status,
    output logic [BCOUNT_W-1:0]      o_byte_count,
    output logic                     o_last
);

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    t_job job_in;
    t_job job_head;

    b64d_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_char_in   (i_char_in),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_job       (job_in)
    );

    b64d_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (job_head)
    );

    b64d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_head       (job_head),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_data_byte  (o_data_byte),
        .o_is_status  (o_is_status),
        .o_status     (o_status),
        .o_byte_count (o_byte_count),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for base64_stream_decoder_core. A driver feeds character
// words from a queue, and a built-in decoder predicts every byte and status
// word. A monitor compares each result word field by field. Phases change the
// end character and the flow-control pattern. One long receiver hold-off
// backs the block up.
// ----------------------------------------------------------------------------
module tb;
    import b64d_pkg::*;

    localparam int         CYCLE_LIMIT = 1_000_000;
    localparam int         HOLD_CYCLES = 400;
    localparam logic [6:0] DIGIT_BAD   = 7'd64;

    typedef struct packed {
        logic [CHAR_W-1:0]   data_byte;
        logic                is_status;
        logic                status;
        logic [BCOUNT_W-1:0] byte_count;
        logic                last;
    } t_word;

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic [CHAR_W-1:0]   i_cfg_wdata = '0;
    logic                i_valid     = 1'b0;
    logic [CHAR_W-1:0]   i_char_in   = '0;
    logic                i_ready     = 1'b0;
    logic                o_ready;
    logic                o_valid;
    logic [CHAR_W-1:0]   o_data_byte;
    logic                o_is_status;
    logic                o_status;
    logic [BCOUNT_W-1:0] o_byte_count;
    logic                o_last;

    logic [CHAR_W-1:0] text_chars[$];
    t_word             decoded_words[$];

    // decoder state
    logic [CHAR_W-1:0] end_char_m = '0;
    logic [CHAR_W-1:0] held_m [0:2];
    logic [1:0]        phase_m    = '0;
    logic              err_m      = 1'b0;
    int unsigned       count_m    = 0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit pressure_armed = 1'b0;
    bit pressure_done  = 1'b0;
    int hold_cnt       = 0;
    int fail_cnt       = 0;
    int cycle_cnt      = 0;

    base64_stream_decoder_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_char_in    (i_char_in),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_data_byte  (o_data_byte),
        .o_is_status  (o_is_status),
        .o_status     (o_status),
        .o_byte_count (o_byte_count),
        .o_last       (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [6:0] b64_value(input logic [CHAR_W-1:0] ch);
        logic [6:0] v;
        v = DIGIT_BAD;
        if (ch >= "A" && ch <= "Z") begin
            v = 7'(ch - "A");
        end else if (ch >= "a" && ch <= "z") begin
            v = 7'(ch - "a" + 26);
        end else if (ch >= "0" && ch <= "9") begin
            v = 7'(ch - "0" + 52);
        end else if (ch == "+") begin
            v = 7'd62;
        end else if (ch == "/") begin
            v = 7'd63;
        end
        return v;
    endfunction

    function automatic logic [CHAR_W-1:0] rand_digit();
        int v;
        v = $urandom_range(63);
        if (v < 26) return 8'("A" + v);
        if (v < 52) return 8'("a" + v - 26);
        if (v < 62) return 8'("0" + v - 52);
        return (v == 62) ? 8'("+") : 8'("/");
    endfunction

    task automatic decode_char(input logic [CHAR_W-1:0] ch);
        logic [6:0]        d0, d1, d2, d3;
        logic              bad;
        int                n, i;
        logic [CHAR_W-1:0] b [0:2];
        t_word             w;
        if (ch == end_char_m) begin
            w.data_byte  = '0;
            w.is_status  = 1'b1;
            w.status     = err_m || (phase_m != 2'd0);
            w.byte_count = count_m[BCOUNT_W-1:0];
            w.last       = 1'b1;
            decoded_words.push_back(w);
            phase_m = '0;
            err_m   = 1'b0;
            count_m = 0;
        end else if (!err_m && ch != CH_CR && ch != CH_LF) begin
            if (phase_m != 2'd3) begin
                held_m[phase_m] = ch;
                phase_m = phase_m + 2'd1;
            end else begin
                phase_m = '0;
                d0  = b64_value(held_m[0]);
                d1  = b64_value(held_m[1]);
                d2  = '0;
                d3  = '0;
                bad = (d0 == DIGIT_BAD) || (d1 == DIGIT_BAD);
                if (ch == CH_PAD && held_m[2] == CH_PAD) begin
                    n = 1;
                end else if (ch == CH_PAD) begin
                    d2  = b64_value(held_m[2]);
                    bad = bad || (d2 == DIGIT_BAD);
                    n   = 2;
                end else begin
                    d2  = b64_value(held_m[2]);
                    d3  = b64_value(ch);
                    bad = bad || (d2 == DIGIT_BAD) || (d3 == DIGIT_BAD);
                    n   = 3;
                end
                if (bad) begin
                    err_m = 1'b1;
                end else begin
                    b[0] = {d0[5:0], d1[5:4]};
                    b[1] = {d1[3:0], d2[5:2]};
                    b[2] = {d2[1:0], d3[5:0]};
                    for (i = 0; i < n; i++) begin
                        w.data_byte  = b[i];
                        w.is_status  = 1'b0;
                        w.status     = 1'b0;
                        w.byte_count = '0;
                        w.last       = (i == n - 1);
                        decoded_words.push_back(w);
                    end
                    if (count_m + n > BCOUNT_MAX) begin
                        count_m = BCOUNT_MAX;
                    end else begin
                        count_m = count_m + n;
                    end
                end
            end
        end
    endtask

    // driver
    always @(posedge i_clk) begin : drive_blk
        logic busy;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            busy = i_valid;
            if (i_valid && o_ready) begin
                decode_char(i_char_in);
                busy = 1'b0;
            end
            if (!busy && text_chars.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                i_char_in <= text_chars.pop_front();
                busy = 1'b1;
            end
            i_valid <= busy;
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_cnt++;
        end
    endtask

    // long receiver hold-off
    always @(posedge i_clk) begin : hold_blk
        if (!i_rst_n) begin
            hold_cnt <= 0;
        end else if (pressure_armed && !pressure_done) begin
            hold_cnt      <= HOLD_CYCLES;
            pressure_done <= 1'b1;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin : recv_blk
        t_word w;
        logic  rdy;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (decoded_words.size() == 0) begin
                    $error("unexpected word: data_byte %0h is_status %0b",
                           o_data_byte, o_is_status);
                    fail_cnt++;
                end else begin
                    w = decoded_words.pop_front();
                    check_field("data_byte", w.data_byte, o_data_byte);
                    check_field("is_status", w.is_status, o_is_status);
                    check_field("status", w.status, o_status);
                    check_field("byte_count", w.byte_count, o_byte_count);
                    check_field("last", w.last, o_last);
                end
            end
            if (hold_cnt != 0) begin
                rdy = 1'b0;
            end else begin
                rdy = ($urandom_range(99) >= recv_stall_pct);
            end
            i_ready <= rdy;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_end_char(input logic [CHAR_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        end_char_m = v;
    endtask

    task automatic wait_idle();
        while (text_chars.size() != 0 || i_valid || decoded_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            text_chars.push_back(s[i]);
        end
    endtask

    task automatic push_break();
        logic [CHAR_W-1:0] c;
        c = ($urandom_range(1) != 0) ? CH_CR : CH_LF;
        if (c != end_char_m) begin
            text_chars.push_back(c);
        end
    endtask

    // mostly well-formed messages, some broken ones, some raw noise
    task automatic gen_text(input int n_chars);
        int made, kind, len, q, k, j;
        logic [CHAR_W-1:0] c;
        made = 0;
        while (made < n_chars) begin
            kind = $urandom_range(99);
            if (kind < 70) begin
                len = $urandom_range(5);
                for (q = 0; q < len; q++) begin
                    k = ($urandom_range(99) < 20) ? $urandom_range(2, 1) : 0;
                    for (j = 0; j < 4; j++) begin
                        c = (j >= 4 - k) ? CH_PAD : rand_digit();
                        text_chars.push_back(c);
                        made++;
                        if ($urandom_range(99) < 8) begin
                            push_break();
                        end
                    end
                end
            end else if (kind < 85) begin
                len = $urandom_range(7, 1);
                for (j = 0; j < len; j++) begin
                    c = ($urandom_range(3) == 0) ? CH_PAD : rand_digit();
                    text_chars.push_back(c);
                    made++;
                end
            end else begin
                len = $urandom_range(6, 1);
                for (j = 0; j < len; j++) begin
                    text_chars.push_back(8'($urandom_range(255)));
                    made++;
                end
            end
            text_chars.push_back(end_char_m);
            made++;
        end
    endtask

    task automatic run_phase(input logic [CHAR_W-1:0] ec, input int send_pct,
                             input int recv_pct, input int n_chars);
        write_end_char(ec);
        @(negedge i_clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        gen_text(n_chars);
        wait_idle();
    endtask

    initial begin : main_blk
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // known vectors, padding forms, line breaks, sticky error, open quartet
        write_end_char(8'h00);
        @(negedge i_clk);
        push_text("TWFu");
        text_chars.push_back(CH_CR);
        text_chars.push_back(CH_LF);
        push_text("TQ==");
        push_text("TWE=");
        text_chars.push_back(8'h00);
        push_text("AB=C");
        text_chars.push_back(8'hFF);
        push_text("z");
        text_chars.push_back(8'h00);
        push_text("9");
        text_chars.push_back(8'h00);
        text_chars.push_back(8'h00);
        wait_idle();

        run_phase(CH_LF, 84, 0, 70);
        run_phase(CH_CR, 0, 84, 70);
        run_phase(CH_PAD, 27, 27, 60);
        pressure_armed = 1'b1;
        run_phase(8'($urandom_range(255)), 0, 0, 70);

        if (fail_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
